// ===== design/swfn_pkg.sv =====
`timescale 1ns / 1ps
// shared types, sizes and helpers for the sliding window first negative block
// no dependencies
package swfn_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int WINDOW_MAX   = 1024;

    // fixed width of the window_size register
    localparam int WIN_REG_W = 11;

    localparam int PTR_W   = $clog2(WINDOW_MAX);
    localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
    // positions wrap; ages never exceed the window, so one bit above the pointer is enough
    localparam int POS_W   = $clog2(WINDOW_MAX) + 1;
    localparam int ENTRY_W = SAMPLE_WIDTH + POS_W;

    // register map
    localparam logic REG_WINDOW_SIZE = 1'b0;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] val;
        logic [POS_W-1:0]               pos;
    } t_entry;

    // request from the stream side towards the core
    typedef struct packed {
        logic                           accept;
        logic                           clear;
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           last;
    } t_step_req;

    // result of the accepted request, same cycle
    typedef struct packed {
        logic                           valid;
        logic signed [SAMPLE_WIDTH-1:0] value;
        logic                           last;
    } t_step_res;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] idx);
        return (idx == PTR_W'(WINDOW_MAX - 1)) ? '0 : idx + 1'b1;
    endfunction

endpackage

// ===== design/swfn_ram.sv =====
`timescale 1ns / 1ps
// simple dual port ram holding the negative sample queue entries
// depends on swfn_pkg for depth and entry width
module swfn_ram
    import swfn_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [PTR_W-1:0]   i_waddr,
    input  logic [ENTRY_W-1:0] i_wdata,
    input  logic [PTR_W-1:0]   i_raddr,
    output logic [ENTRY_W-1:0] o_rdata
);

    logic [ENTRY_W-1:0] r_mem [WINDOW_MAX];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/swfn_core.sv =====
`timescale 1ns / 1ps
// queue control: head/tail/count, front entry cache, age check and result
// depends on swfn_pkg and swfn_ram
module swfn_core
    import swfn_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [WIN_REG_W-1:0] i_window_size,
    input  t_step_req            i_req,
    output t_step_res            o_res
);

    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic [POS_W-1:0] r_pos;
    logic [CNT_W-1:0] r_seen, n_seen;
    t_entry           r_f0, n_f0;
    t_entry           r_f1, n_f1;
    t_entry           r_byp;
    logic             r_byp_vld, n_byp_vld;

    logic [ENTRY_W-1:0] mem_q;
    logic [PTR_W-1:0]   rd_head;
    logic [PTR_W-1:0]   raddr;
    logic [CNT_W-1:0]   k_eff;
    logic [CNT_W-1:0]   cnt_d;
    logic [POS_W-1:0]   age;
    logic               drop;
    logic               push;
    logic               stream_end;
    t_entry             f2;
    t_entry             pe;

    always_comb begin
        if (i_window_size == '0) begin
            k_eff = CNT_W'(1);
        end else if (i_window_size > WIN_REG_W'(WINDOW_MAX)) begin
            k_eff = CNT_W'(WINDOW_MAX);
        end else begin
            k_eff = CNT_W'(i_window_size);
        end
    end

    always_comb begin
        // third entry comes from the ram, or from a push that hit its slot last cycle
        f2     = r_byp_vld ? r_byp : t_entry'(mem_q);
        pe.val = i_req.sample;
        pe.pos = r_pos;

        age  = r_pos - r_f0.pos;
        drop = (r_count != '0) && (CNT_W'(age) >= k_eff);
        cnt_d = r_count - CNT_W'(drop);
        // room is checked after the front drop
        push = i_req.sample[SAMPLE_WIDTH-1] && (cnt_d < CNT_W'(WINDOW_MAX));

        if (drop) begin
            n_f0 = (r_count >= CNT_W'(2)) ? r_f1 : pe;
            n_f1 = (r_count >= CNT_W'(3)) ? f2   : pe;
        end else begin
            n_f0 = (r_count >= CNT_W'(1)) ? r_f0 : pe;
            n_f1 = (r_count >= CNT_W'(2)) ? r_f1 : pe;
        end

        n_head    = drop ? next_slot(r_head) : r_head;
        n_tail    = push ? next_slot(r_tail) : r_tail;
        n_count   = cnt_d + CNT_W'(push);
        n_seen    = (r_seen < k_eff) ? r_seen + 1'b1 : r_seen;
        n_byp_vld = push && (cnt_d == CNT_W'(2));

        stream_end = i_req.clear || (i_req.accept && i_req.last);
        if (stream_end) begin
            rd_head = '0;
        end else if (i_req.accept) begin
            rd_head = n_head;
        end else begin
            rd_head = r_head;
        end
        raddr = next_slot(next_slot(rd_head));
    end

    always_comb begin
        o_res.valid = i_req.accept && (n_seen >= k_eff);
        o_res.value = (n_count != '0) ? n_f0.val : '0;
        o_res.last  = i_req.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_pos     <= '0;
            r_seen    <= '0;
            r_byp_vld <= 1'b0;
        end else if (stream_end) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_pos     <= '0;
            r_seen    <= '0;
            r_byp_vld <= 1'b0;
        end else if (i_req.accept) begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_pos     <= r_pos + 1'b1;
            r_seen    <= n_seen;
            r_byp_vld <= n_byp_vld;
        end else begin
            r_byp_vld <= 1'b0;
        end
    end

    // front cache, valid as far as the count says
    always_ff @(posedge i_clk) begin
        if (i_req.accept) begin
            r_f0  <= n_f0;
            r_f1  <= n_f1;
            r_byp <= pe;
        end
    end

    swfn_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.accept && push),
        .i_waddr (r_tail),
        .i_wdata (ENTRY_W'(pe)),
        .i_raddr (raddr),
        .o_rdata (mem_q)
    );

endmodule

// ===== design/sliding_window_first_negative.sv =====
`timescale 1ns / 1ps
// top level: stream ports, apb register and output register around the queue core
// depends on swfn_pkg and swfn_core
//
// usage
//   s_axis carries one signed sample per request in tdata, tlast marks the last
//   sample of a stream. m_axis returns the oldest negative sample of the last
//   window_size samples (zero if none) in tdata, tlast set on the result of the
//   stream's last sample. the first window_size-1 samples of a stream give no
//   result; a stream shorter than the window gives none at all.
//   window_size is written through the apb port at address 0 while the block is
//   idle; a write also clears all stream state. 0 acts as 1, values above 1024
//   act as 1024; only the low 11 bits of pwdata are kept in the register.
//   output: a result is registered and shows on m_axis in the cycle after its sample is accepted.
//   throughput: one sample per cycle while m_axis does not stall; the queue ram gives a read and a
//   write each cycle, the front entries are cached in registers so drops need no stall.
//   reset: synchronous, clears pointers, counts and window_size (back to 1);
//   the queue ram needs no clearing pass since only written entries are read.
//   stall: the output register keeps its result while m_axis_tready is low;
//   s_axis_tready stays high as long as that register is empty or drains.
module sliding_window_first_negative
    import swfn_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // apb configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // sample stream in
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [SAMPLE_WIDTH-1:0] s_axis_tdata,   // [31:0] sample
    input  logic                    s_axis_tlast,   // last_sample
    // result stream out
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [SAMPLE_WIDTH-1:0] m_axis_tdata,   // [31:0] first_negative
    output logic                    m_axis_tlast    // end_of_stream
);

    logic [WIN_REG_W-1:0]    r_window_size;
    logic                    r_out_vld;
    logic [SAMPLE_WIDTH-1:0] r_out_data;
    logic                    r_out_last;

    logic      cfg_wr;
    logic      in_acc;
    t_step_req req;
    t_step_res res;

    // register write in the access phase, only the window register exists
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_SIZE);
    assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? 32'(r_window_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WIN_REG_W'(1);
        end else if (cfg_wr) begin
            r_window_size <= pwdata[WIN_REG_W-1:0];
        end
    end

    // take a new sample whenever the output register is free or being emptied
    assign s_axis_tready = !r_out_vld || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        req.accept = in_acc;
        req.clear  = cfg_wr;
        req.sample = s_axis_tdata;
        req.last   = s_axis_tlast;
    end

    swfn_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_window_size (r_window_size),
        .i_req         (req),
        .o_res         (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res.valid) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_out_data <= res.value;
            r_out_last <= res.last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    // input side only backs off while a result waits
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output register");

    // a new result always comes from a sample accepted the cycle before
    a_result_from_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(in_acc))
        else $error("result without an accepted request");

    // a result is negative or zero
    a_result_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata != '0)) |-> m_axis_tdata[SAMPLE_WIDTH-1])
        else $error("nonzero result is not negative");
`endif

endmodule
